// File: sv/codepoint_glyph_row_renderer_assert.svh
// Assertion macros shared by the glyph row renderer RTL.
`ifndef CODEPOINT_GLYPH_ROW_RENDERER_ASSERT_SVH
`define CODEPOINT_GLYPH_ROW_RENDERER_ASSERT_SVH

// Checked only while the block is out of reset.
`define CGR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define CGR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/cgr_pkg.sv
// Types, constants and the color palette of the glyph row renderer.
package cgr_pkg;

  localparam int TABLE_ENTRIES_DEF = 1024;
  localparam int GLYPH_COUNT_DEF   = 512;

  localparam int CMD_W  = 2;
  localparam int CP_W   = 21;
  localparam int CPS_W  = 16;
  localparam int FI_W   = 9;
  localparam int ROW_W  = 4;
  localparam int PIX_W  = 8;
  localparam int ATTR_W = 8;
  localparam int COL_W  = 4;
  localparam int RGB_W  = 8;
  localparam int ENTRY_W = CPS_W + FI_W;

  localparam logic [CPS_W-1:0] REPLACEMENT_CP = 16'hFFFD;
  localparam logic [CP_W-1:0]  MAX_STORED_CP  = 21'h00FFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND    = 2'd0,
    CMD_WRITE_ROW = 2'd1,
    CMD_RENDER    = 2'd2,
    CMD_CLEAR     = 2'd3
  } cmd_e;

  typedef logic [3*RGB_W-1:0] rgb_t;

  localparam rgb_t PALETTE [16] = '{
    24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
    24'hAA0000, 24'hAA00AA, 24'hAAAA00, 24'hAAAAAA,
    24'h555555, 24'h0000FF, 24'h00FF00, 24'h00FFFF,
    24'hFF0000, 24'hFF00FF, 24'hFFFF00, 24'hFFFFFF
  };

  function automatic rgb_t palette_rgb(input logic [COL_W-1:0] color);
    return PALETTE[color];
  endfunction

endpackage

// File: sv/cgr_ifs.sv
// Command, pixel and configuration channel interfaces of the glyph row renderer.
interface cgr_cmd_if import cgr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CP_W-1:0]   code_point;
  logic [FI_W-1:0]   font_index;
  logic [ROW_W-1:0]  row_number;
  logic [PIX_W-1:0]  row_bits;
  logic [ATTR_W-1:0] attribute;

  modport source (output valid, cmd, code_point, font_index, row_number, row_bits,
                  attribute, input ready);
  modport sink (input valid, cmd, code_point, font_index, row_number, row_bits,
                attribute, output ready);
endinterface

interface cgr_pix_if import cgr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] color_index;
  logic [RGB_W-1:0] red;
  logic [RGB_W-1:0] green;
  logic [RGB_W-1:0] blue;
  logic [FI_W-1:0]  glyph_used;
  logic             last_pixel;

  modport source (output valid, color_index, red, green, blue, glyph_used, last_pixel,
                  input ready);
  modport sink (input valid, color_index, red, green, blue, glyph_used, last_pixel,
                output ready);
endinterface

interface cgr_cfg_if ();
  logic valid;
  logic ready;
  logic row_doubling;

  modport source (output valid, row_doubling, input ready);
  modport sink (input valid, row_doubling, output ready);
endinterface

// File: sv/cgr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/codepoint_glyph_row_renderer.sv
// Top level of the text-mode glyph row renderer.
//
// Channels: cmd_i takes one command per transfer (append table entry, write
// glyph row, render row, clear table); pix_o delivers eight pixel transfers for
// each render, leftmost pixel first, with last_pixel on the eighth; cfg_i
// writes the row doubling bit and is always ready.
// Append, glyph row write and clear leave the block in S_IDLE, and the next
// command may follow in the next cycle. A render runs a binary search over the
// code table; each probe passes through S_PROBE and S_CMP because of the
// registered read of the table RAM. On a miss the block reads the last entry and
// takes its glyph if that entry holds code point FFFD, else it reads entry 0 and
// takes its glyph; an empty table selects glyph 0.
// Reset empties the table by clearing the entry count and sets row doubling.
// The table and glyph store contents are not cleared, so there is no clearing
// pass. When the receiver stalls, the output register holds its pixel and the
// sequencer waits; after the eighth pixel is loaded the block takes a new command.
`include "codepoint_glyph_row_renderer_assert.svh"

module codepoint_glyph_row_renderer import cgr_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int GLYPH_COUNT   = GLYPH_COUNT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cgr_cmd_if.sink   cmd_i,
  cgr_pix_if.source pix_o,
  cgr_cfg_if.sink   cfg_i
);

  localparam int TAW    = $clog2(TABLE_ENTRIES);
  localparam int CW     = $clog2(TABLE_ENTRIES + 1);
  localparam int GAW    = $clog2(GLYPH_COUNT * 8);
  localparam int FI_PAD = 32 - FI_W;
  localparam int CP_PAD = CP_W - CPS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_LAST,
    S_FIRST,
    S_GLYPH_RD,
    S_GLYPH_WAIT,
    S_EMIT
  } state_e;

  state_e            state_q;
  logic [CW-1:0]     count_q;
  logic [CW-1:0]     lo_q;
  logic [CW-1:0]     hi_q;
  logic              dbl_q;
  logic [CP_W-1:0]   cp_q;
  logic [ROW_W-1:0]  row_q;
  logic [ATTR_W-1:0] attr_q;
  logic [FI_W-1:0]   glyph_q;
  logic [PIX_W-1:0]  pattern_q;
  logic [2:0]        pix_cnt_q;
  logic              out_valid_q;
  logic [COL_W-1:0]  color_q;
  rgb_t              rgb_q;
  logic [FI_W-1:0]   used_q;
  logic              last_q;

  logic [CW:0]          mid_sum;
  logic [CW-1:0]        mid;
  logic [CW-1:0]        last_idx;
  logic                 tbl_we;
  logic                 tbl_re;
  logic [TAW-1:0]       tbl_raddr;
  logic [ENTRY_W-1:0]   tbl_rdata;
  logic [CP_W-1:0]      tbl_cp;
  logic [FI_W-1:0]      tbl_glyph;
  logic                 cp_hit;
  logic                 cp_less;
  logic                 glyph_we;
  logic                 glyph_re;
  logic [2:0]           grow;
  logic [PIX_W-1:0]     glyph_rdata;
  logic                 glyph_ok;
  logic                 accept;
  logic                 load;
  logic [COL_W-1:0]     pix_color;
  cmd_e                 cmd;

  assign accept   = cmd_i.valid && cmd_i.ready;
  assign cmd      = cmd_e'(cmd_i.cmd);
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = mid_sum[CW:1];
  assign last_idx = count_q - CW'(1);

  assign tbl_we = accept && cmd == CMD_APPEND && count_q < CW'(TABLE_ENTRIES)
                  && cmd_i.code_point <= MAX_STORED_CP
                  && {{FI_PAD{1'b0}}, cmd_i.font_index} < GLYPH_COUNT;
  assign glyph_we = accept && cmd == CMD_WRITE_ROW && !cmd_i.row_number[3]
                    && {{FI_PAD{1'b0}}, cmd_i.font_index} < GLYPH_COUNT;

  always_comb begin
    tbl_re    = 1'b0;
    tbl_raddr = '0;
    unique case (state_q)
      S_PROBE: begin
        tbl_re    = 1'b1;
        tbl_raddr = (lo_q < hi_q) ? mid[TAW-1:0] : last_idx[TAW-1:0];
      end
      S_LAST: begin
        tbl_re    = 1'b1;
        tbl_raddr = '0;
      end
      default: begin
        tbl_re    = 1'b0;
        tbl_raddr = '0;
      end
    endcase
  end

  assign tbl_cp    = {{CP_PAD{1'b0}}, tbl_rdata[CPS_W-1:0]};
  assign tbl_glyph = tbl_rdata[ENTRY_W-1:CPS_W];
  assign cp_hit    = tbl_cp == cp_q;
  assign cp_less   = tbl_cp < cp_q;

  assign grow     = dbl_q ? row_q[3:1] : row_q[2:0];
  assign glyph_re = state_q == S_GLYPH_RD;
  assign glyph_ok = {{FI_PAD{1'b0}}, glyph_q} < GLYPH_COUNT;

  assign load      = state_q == S_EMIT && (!out_valid_q || pix_o.ready);
  assign pix_color = pattern_q[PIX_W-1] ? attr_q[3:0] : attr_q[7:4];

  cgr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_code_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (count_q[TAW-1:0]),
    .wdata_i ({cmd_i.font_index, cmd_i.code_point[CPS_W-1:0]}),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  cgr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (GLYPH_COUNT * 8)
  ) u_glyph_store (
    .clk_i   (clk_i),
    .we_i    (glyph_we),
    .waddr_i (GAW'({cmd_i.font_index, cmd_i.row_number[2:0]})),
    .wdata_i (cmd_i.row_bits),
    .re_i    (glyph_re),
    .raddr_i (GAW'({glyph_q, grow})),
    .rdata_o (glyph_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      dbl_q       <= 1'b1;
      cp_q        <= '0;
      row_q       <= '0;
      attr_q      <= '0;
      glyph_q     <= '0;
      pattern_q   <= '0;
      pix_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      color_q     <= '0;
      rgb_q       <= '0;
      used_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        dbl_q <= cfg_i.row_doubling;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pix_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            cp_q   <= cmd_i.code_point;
            row_q  <= cmd_i.row_number;
            attr_q <= cmd_i.attribute;
            unique case (cmd)
              CMD_APPEND: begin
                if (tbl_we) begin
                  count_q <= count_q + CW'(1);
                end
              end
              CMD_CLEAR: begin
                count_q <= '0;
              end
              CMD_RENDER: begin
                lo_q <= '0;
                hi_q <= count_q;
                if (count_q == '0) begin
                  glyph_q <= '0;
                  state_q <= S_GLYPH_RD;
                end else begin
                  state_q <= S_PROBE;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_PROBE: begin
          state_q <= (lo_q < hi_q) ? S_CMP : S_LAST;
        end
        S_CMP: begin
          if (cp_hit) begin
            glyph_q <= tbl_glyph;
            state_q <= S_GLYPH_RD;
          end else begin
            if (cp_less) begin
              lo_q <= mid + CW'(1);
            end else begin
              hi_q <= mid;
            end
            state_q <= S_PROBE;
          end
        end
        S_LAST: begin
          if (tbl_rdata[CPS_W-1:0] == REPLACEMENT_CP) begin
            glyph_q <= tbl_glyph;
            state_q <= S_GLYPH_RD;
          end else begin
            state_q <= S_FIRST;
          end
        end
        S_FIRST: begin
          glyph_q <= tbl_glyph;
          state_q <= S_GLYPH_RD;
        end
        S_GLYPH_RD: begin
          state_q <= S_GLYPH_WAIT;
        end
        S_GLYPH_WAIT: begin
          pattern_q <= glyph_ok ? glyph_rdata : '0;
          pix_cnt_q <= '0;
          state_q   <= S_EMIT;
        end
        S_EMIT: begin
          if (load) begin
            color_q   <= pix_color;
            rgb_q     <= palette_rgb(pix_color);
            used_q    <= glyph_q;
            last_q    <= pix_cnt_q == 3'd7;
            pattern_q <= pattern_q << 1;
            pix_cnt_q <= pix_cnt_q + 3'd1;
            if (pix_cnt_q == 3'd7) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign cmd_i.ready       = state_q == S_IDLE;
  assign cfg_i.ready       = 1'b1;
  assign pix_o.valid       = out_valid_q;
  assign pix_o.color_index = color_q;
  assign pix_o.red         = rgb_q[3*RGB_W-1:2*RGB_W];
  assign pix_o.green       = rgb_q[2*RGB_W-1:RGB_W];
  assign pix_o.blue        = rgb_q[RGB_W-1:0];
  assign pix_o.glyph_used  = used_q;
  assign pix_o.last_pixel  = last_q;

  `CGR_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !pix_o.valid, "pixel offered after reset")
  `CGR_ASSERT(a_count_bound, count_q <= CW'(TABLE_ENTRIES), "entry count overflow")
  `CGR_ASSERT(a_search_window, state_q == S_PROBE |-> lo_q <= hi_q && hi_q <= count_q, "search window out of range")
  `CGR_ASSERT(a_row_done, load && pix_cnt_q == 3'd7 |=> state_q == S_IDLE && pix_o.valid && pix_o.last_pixel, "row end not flagged")

endmodule

// File: tb/sv/codepoint_glyph_row_renderer_tb.sv
// Self-checking testbench for the code point glyph row renderer, with its own predictor.
`timescale 1ns / 100ps

module codepoint_glyph_row_renderer_tb import cgr_pkg::*; ();

  localparam int NUM_ENTRIES = 1024;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;
  localparam logic [15:0] FALLBACK_CP = 16'hFFFD;
  localparam logic [20:0] TOP_CP = 21'h10FFFF;

  typedef struct packed {
    logic [3:0] color;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] glyph;
    logic       last;
  } pixel_t;

  localparam logic [23:0] COLORS [16] = '{
    24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
    24'hAA0000, 24'hAA00AA, 24'hAAAA00, 24'hAAAAAA,
    24'h555555, 24'h0000FF, 24'h00FF00, 24'h00FFFF,
    24'hFF0000, 24'hFF00FF, 24'hFFFF00, 24'hFFFFFF
  };

  logic clk_i;
  logic rst_ni;

  cgr_cmd_if cmd_if ();
  cgr_pix_if pix_if ();
  cgr_cfg_if cfg_if ();

  codepoint_glyph_row_renderer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .pix_o  (pix_if),
    .cfg_i  (cfg_if)
  );

  logic [15:0] tbl_cp [NUM_ENTRIES];
  logic [8:0]  tbl_glyph [NUM_ENTRIES];
  int          entry_cnt;
  logic [7:0]  glyph_rows [4096];
  bit          row_written [4096];
  bit          double_rows;

  pixel_t expected_pixels [$];
  int     errors;
  bit     tx_idle;
  bit     rx_idle;
  bit     hold_req;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [8:0] find_glyph(logic [20:0] cp);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = entry_cnt;
    if (entry_cnt == 0) return 9'd0;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if ({5'd0, tbl_cp[mid]} == cp) return tbl_glyph[mid];
      if ({5'd0, tbl_cp[mid]} < cp) lo = mid + 1;
      else hi = mid;
    end
    if (tbl_cp[entry_cnt-1] == FALLBACK_CP) return tbl_glyph[entry_cnt-1];
    return tbl_glyph[0];
  endfunction

  task automatic report_error(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  always @(posedge clk_i) begin
    pixel_t seen;
    pixel_t want;
    if (rst_ni && pix_if.valid && pix_if.ready) begin
      seen = '{pix_if.color_index, pix_if.red, pix_if.green, pix_if.blue,
               pix_if.glyph_used, pix_if.last_pixel};
      if (expected_pixels.size() == 0) begin
        report_error($sformatf("Unexpected pixel transfer: color %0d glyph %0d last %0b",
                               seen.color, seen.glyph, seen.last));
      end else begin
        want = expected_pixels.pop_front();
        if (seen !== want) begin
          report_error($sformatf(
            "Pixel mismatch: expected color %0d rgb %02h%02h%02h glyph %0d last %0b, got color %0d rgb %02h%02h%02h glyph %0d last %0b",
            want.color, want.red, want.green, want.blue, want.glyph, want.last,
            seen.color, seen.red, seen.green, seen.blue, seen.glyph, seen.last));
        end
      end
    end
  end

  initial begin
    int rx_hold;
    int rx_gap;
    rx_hold = 0;
    rx_gap = 0;
    pix_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        rx_hold = HOLD_CYCLES;
      end
      if (rx_hold > 0) begin
        pix_if.ready <= 1'b0;
        rx_hold--;
      end else if (rx_gap > 0) begin
        pix_if.ready <= 1'b0;
        rx_gap--;
      end else begin
        pix_if.ready <= 1'b1;
        if (rx_idle && $urandom_range(0, 3) == 0) rx_gap = pick_gap();
      end
    end
  end

  task automatic apply_cmd(cmd_e c, logic [20:0] cp, logic [8:0] fi, logic [3:0] row,
                           logic [7:0] bits, logic [7:0] attr);
    logic [8:0] g;
    logic [2:0] gr;
    logic [7:0] pattern;
    logic [3:0] color;
    case (c)
      CMD_APPEND: begin
        if (entry_cnt < NUM_ENTRIES && cp <= 21'h00FFFF) begin
          tbl_cp[entry_cnt] = cp[15:0];
          tbl_glyph[entry_cnt] = fi;
          entry_cnt++;
        end
      end
      CMD_WRITE_ROW: begin
        if (row < 4'd8) begin
          glyph_rows[{fi, row[2:0]}] = bits;
          row_written[{fi, row[2:0]}] = 1'b1;
        end
      end
      CMD_CLEAR: entry_cnt = 0;
      CMD_RENDER: begin
        g = find_glyph(cp);
        gr = double_rows ? row[3:1] : row[2:0];
        pattern = glyph_rows[{g, gr}];
        for (int i = 0; i < 8; i++) begin
          color = pattern[7-i] ? attr[3:0] : attr[7:4];
          expected_pixels.push_back('{color, COLORS[color][23:16], COLORS[color][15:8],
                                      COLORS[color][7:0], g, i == 7});
        end
      end
    endcase
  endtask

  task automatic send_cmd(cmd_e c, logic [20:0] cp, logic [8:0] fi, logic [3:0] row,
                          logic [7:0] bits, logic [7:0] attr);
    int gap;
    gap = (tx_idle && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.cmd <= c;
    cmd_if.code_point <= cp;
    cmd_if.font_index <= fi;
    cmd_if.row_number <= row;
    cmd_if.row_bits <= bits;
    cmd_if.attribute <= attr;
    do @(posedge clk_i); while (!cmd_if.ready);
    apply_cmd(c, cp, fi, row, bits, attr);
  endtask

  task automatic append(logic [20:0] cp, logic [8:0] fi);
    send_cmd(CMD_APPEND, cp, fi, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)));
  endtask

  task automatic write_row(logic [8:0] fi, logic [3:0] row, logic [7:0] bits);
    send_cmd(CMD_WRITE_ROW, 21'($urandom_range(0, TOP_CP)), fi, row, bits,
             8'($urandom_range(0, 255)));
  endtask

  task automatic clear_table();
    send_cmd(CMD_CLEAR, 21'($urandom_range(0, TOP_CP)), 9'($urandom_range(0, 511)),
             4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)));
  endtask

  // The glyph row that a render will read is written first if it never was.
  task automatic render(logic [20:0] cp, logic [3:0] row, logic [7:0] attr);
    logic [8:0] g;
    logic [2:0] gr;
    g = find_glyph(cp);
    gr = double_rows ? row[3:1] : row[2:0];
    if (!row_written[{g, gr}]) write_row(g, {1'b0, gr}, 8'($urandom_range(0, 255)));
    send_cmd(CMD_RENDER, cp, 9'($urandom_range(0, 511)), row, 8'($urandom_range(0, 255)),
             attr);
  endtask

  task automatic settle();
    cmd_if.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_doubling(bit value);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.row_doubling <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    double_rows = value;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_empty_table();
    logic [7:0] patterns [8] = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'h80, 8'h01, 8'hF0, 8'h0F};
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    for (int r = 0; r < 8; r++) write_row(9'd0, r[3:0], patterns[r]);
    render(21'd0, 4'd0, 8'h00);
    render(TOP_CP, 4'd15, 8'hFF);
    render(21'h00FFFD, 4'd7, 8'hF1);
  endtask

  task automatic test_lookup_cases();
    clear_table();
    append(21'h000000, 9'd511);
    append(21'h000041, 9'd3);
    append(21'h010000, 9'd4);
    append(21'h001234, 9'd256);
    append(21'h00FFFD, 9'd5);
    render(21'h000041, 4'd3, 8'h1E);
    render(21'h000000, 4'd14, 8'hE1);
    render(21'h007777, 4'd5, 8'h7C);
    render(21'h010000, 4'd1, 8'hC7);
    write_row(9'd3, 4'd9, 8'hFF);
    render(21'h000041, 4'd9, 8'h42);
    append(21'h000010, 9'd7);
    render(21'h007777, 4'd2, 8'h9A);
    render(21'h000010, 4'd6, 8'hA9);
    clear_table();
    render(21'h001234, 4'd11, 8'h35);
  endtask

  task automatic test_row_wrap();
    set_doubling(1'b0);
    render(21'h000020, 4'd15, 8'h8F);
    render(21'h000020, 4'd8, 8'hF8);
    render(21'h000020, 4'd0, 8'h6D);
  endtask

  task automatic test_full_table();
    logic [20:0] cp;
    set_doubling(1'b1);
    tx_idle = 1'b0;
    clear_table();
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      cp = (i == NUM_ENTRIES - 1) ? {5'd0, FALLBACK_CP}
                                  : 21'(i * 64 + $urandom_range(0, 63));
      append(cp, 9'($urandom_range(0, 511)));
    end
    append(21'h000042, 9'd9);
    tx_idle = 1'b1;
    for (int i = 0; i < 6; i++)
      render({5'd0, tbl_cp[$urandom_range(0, NUM_ENTRIES - 1)]}, 4'($urandom_range(0, 15)),
             8'($urandom_range(0, 255)));
    render({5'd0, tbl_cp[0]}, 4'd4, 8'h17);
    render(21'($urandom_range(0, 16'hFFFF)), 4'd12, 8'h71);
    render(21'($urandom_range(21'h010000, TOP_CP)), 4'd3, 8'hB4);
  endtask

  task automatic test_backpressure();
    settle();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++)
      render(21'($urandom_range(0, TOP_CP)), 4'($urandom_range(0, 15)),
             8'($urandom_range(0, 255)));
    settle();
  endtask

  task automatic random_phase(int n_items, bit dbl, bit tx_on, bit rx_on);
    int done_items;
    int pick;
    int k;
    logic [20:0] cp;
    set_doubling(dbl);
    tx_idle = tx_on;
    rx_idle = rx_on;
    done_items = 0;
    while (done_items < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        clear_table();
        done_items++;
        k = $urandom_range(0, 24);
        cp = 21'($urandom_range(0, 200));
        for (int i = 0; i < k && cp < 21'h00FFFD; i++) begin
          append(cp, 9'($urandom_range(0, 511)));
          done_items++;
          cp = cp + 21'($urandom_range(1, 3000));
        end
        if ($urandom_range(0, 1) == 1 && entry_cnt > 0 && tbl_cp[entry_cnt-1] < FALLBACK_CP) begin
          append({5'd0, FALLBACK_CP}, 9'($urandom_range(0, 511)));
          done_items++;
        end
      end else if (pick < 15) begin
        if ($urandom_range(0, 1) == 1) begin
          cp = 21'($urandom_range(0, TOP_CP));
          append(cp, 9'($urandom_range(0, 511)));
          if (cp <= 21'h00FFFF) done_items++;
        end else begin
          write_row(9'($urandom_range(0, 511)), 4'($urandom_range(8, 15)),
                    8'($urandom_range(0, 255)));
        end
      end else if (pick < 30) begin
        write_row(9'($urandom_range(0, 511)), 4'($urandom_range(0, 7)),
                  8'($urandom_range(0, 255)));
        done_items++;
      end else begin
        k = $urandom_range(0, 9);
        if (entry_cnt > 0 && k < 6) cp = {5'd0, tbl_cp[$urandom_range(0, entry_cnt - 1)]};
        else if (k < 8) cp = 21'($urandom_range(0, 16'hFFFF));
        else cp = 21'($urandom_range(0, TOP_CP));
        render(cp, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
        done_items++;
      end
    end
  endtask

  initial begin
    errors = 0;
    entry_cnt = 0;
    double_rows = 1'b1;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_req = 1'b0;
    foreach (row_written[i]) row_written[i] = 1'b0;
    rst_ni = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.cmd = CMD_APPEND;
    cmd_if.code_point = '0;
    cmd_if.font_index = '0;
    cmd_if.row_number = '0;
    cmd_if.row_bits = '0;
    cmd_if.attribute = '0;
    cfg_if.valid = 1'b0;
    cfg_if.row_doubling = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_lookup_cases();
    test_row_wrap();
    test_full_table();
    test_backpressure();
    random_phase(45, 1'b0, 1'b1, 1'b1);
    random_phase(45, 1'b1, 1'b1, 1'b0);
    random_phase(45, 1'b0, 1'b0, 1'b1);
    random_phase(45, 1'b1, 1'b0, 1'b0);
    random_phase(45, 1'b1, 1'b1, 1'b1);
    random_phase(45, 1'b0, 1'b1, 1'b1);
    settle();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
